// File: design/cfd_boundary_face_values_assert.svh
// Assertion macros for the boundary face value block.
`ifndef CFD_BOUNDARY_FACE_VALUES_ASSERT_SVH
`define CFD_BOUNDARY_FACE_VALUES_ASSERT_SVH
`ifndef SYNTHESIS
// Implication checked at every rising edge outside reset.
`define CBFV_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("boundary face value check failed");
// Condition that must never hold outside reset.
`define CBFV_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("boundary face value condition seen");
`else
`define CBFV_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define CBFV_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// File: design/cbfv_pkg.sv
// Shared types, codes and helper functions for the boundary face value block.
package cbfv_pkg;

    localparam int QuotBits = 64;

    localparam logic signed [47:0] ValMax = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] ValMin = 48'sh8000_0000_0000;
    localparam logic [63:0] QuotPosLimit = 64'h0000_7FFF_FFFF_FFFF;
    localparam logic [63:0] QuotNegLimit = 64'h0000_8000_0000_0000;

    localparam logic [1:0] SmFixed       = 2'd0;
    localparam logic [1:0] SmZeroGrad    = 2'd1;
    localparam logic [1:0] SmInletOutlet = 2'd2;

    localparam logic [2:0] VmFixed    = 3'd0;
    localparam logic [2:0] VmZeroGrad = 3'd1;
    localparam logic [2:0] VmSlip     = 3'd2;
    localparam logic [2:0] VmNoSlip   = 3'd3;
    localparam logic [2:0] VmSurface  = 3'd4;
    localparam logic [2:0] VmMassFlux = 3'd5;

    localparam logic [2:0] RegScalarModes = 3'd0;
    localparam logic [2:0] RegPressure    = 3'd1;
    localparam logic [2:0] RegTemperature = 3'd2;
    localparam logic [2:0] RegVelMode     = 3'd3;
    localparam logic [2:0] RegVelX        = 3'd4;
    localparam logic [2:0] RegVelY        = 3'd5;
    localparam logic [2:0] RegVelZ        = 3'd6;
    localparam logic [2:0] RegGasConstant = 3'd7;

    typedef struct packed {
        logic signed [47:0] fp;
        logic signed [47:0] ft;
        logic [2:0][47:0]   fv;
        logic [2:0][17:0]   n;
        logic               p_zero;
        logic               b_zero;
        logic               b_neg;
        logic               q_neg;
    } t_side;

    function automatic logic signed [47:0] sat48(input logic signed [127:0] x);
        if (x > 128'(ValMax)) begin
            return ValMax;
        end else if (x < 128'(ValMin)) begin
            return ValMin;
        end
        return x[47:0];
    endfunction

    function automatic logic [47:0] mag48(input logic signed [47:0] x);
        return x[47] ? 48'(-x) : x;
    endfunction

    function automatic logic signed [47:0] pick_scalar(input logic [1:0] mode,
                                                       input logic signed [47:0] fixed_v,
                                                       input logic signed [47:0] cell_v,
                                                       input logic inflow);
        case (mode)
            SmFixed:       return fixed_v;
            SmInletOutlet: return inflow ? fixed_v : cell_v;
            default:       return cell_v;
        endcase
    endfunction

endpackage

// File: design/cfd_boundary_face_values.sv
// Top level of the boundary face value block: registers, pipeline and output stage.
//
// Usage: one boundary face per input transaction on the valid/ready input
// channel (cell pressure, velocity, temperature and face unit normal), one
// face result per output transaction on the valid/ready output channel
// (face pressure, velocity, temperature and divide_fault).
// Patch settings sit in eight 64-bit registers on the APB port at byte
// address 8*index; write them only while no transaction is in flight.
// Pipeline: five front stages, 64 divider stages (one quotient bit each, which
// sets the depth) and two back stages, then the output register.
// Throughput: one transaction per cycle, sustained, in every mode, while the
// receiver takes each result (see Stall).
// Stall: when the output register holds a result the receiver has not taken,
// the whole pipeline holds and input ready drops; nothing is dropped or
// repeated, and it advances again the cycle the result is taken.
// Reset (synchronous, active low) empties the pipeline and loads the
// register defaults: zero gradient everywhere, gas constant 287.
module cfd_boundary_face_values (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [47:0] i_cell_pressure,
    input  logic signed [47:0] i_cell_vel_x,
    input  logic signed [47:0] i_cell_vel_y,
    input  logic signed [47:0] i_cell_vel_z,
    input  logic signed [47:0] i_cell_temperature,
    input  logic signed [17:0] i_normal_x,
    input  logic signed [17:0] i_normal_y,
    input  logic signed [17:0] i_normal_z,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [47:0] o_face_pressure,
    output logic signed [47:0] o_face_vel_x,
    output logic signed [47:0] o_face_vel_y,
    output logic signed [47:0] o_face_vel_z,
    output logic signed [47:0] o_face_temperature,
    output logic               o_divide_fault
);
    import cbfv_pkg::*;

    // configuration registers
    logic [3:0]         r_scalar_modes;
    logic signed [47:0] r_pressure_value;
    logic signed [47:0] r_temperature_value;
    logic [2:0]         r_velocity_mode;
    logic signed [47:0] r_velocity_value_x;
    logic signed [47:0] r_velocity_value_y;
    logic signed [47:0] r_velocity_value_z;
    logic [46:0]        r_gas_constant;

    logic               w_en;
    logic               w_front_valid, w_div_valid;
    logic [63:0]        w_num, w_quot;
    logic [47:0]        w_den;
    t_side              w_front_side, w_div_side;
    logic signed [47:0] w_speed;
    logic signed [47:0] w_face [3];
    logic               w_fault;

    logic               r_t1_valid, r_t2_valid, r_out_valid;
    logic signed [48:0] r_t1_ns;
    t_side              r_t1_side, r_t2_side;
    logic signed [66:0] r_t2_mp [3];
    logic signed [47:0] r_out_face [3];
    logic signed [47:0] r_out_fp, r_out_ft;
    logic               r_out_fault;

    // advance the whole pipeline whenever the output register is free
    assign w_en       = !r_out_valid || i_out_ready;
    assign o_in_ready = w_en;
    assign pready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scalar_modes      <= 4'd5;
            r_pressure_value    <= '0;
            r_temperature_value <= '0;
            r_velocity_mode     <= VmZeroGrad;
            r_velocity_value_x  <= '0;
            r_velocity_value_y  <= '0;
            r_velocity_value_z  <= '0;
            r_gas_constant      <= 47'd18808832;
        end else if (psel && penable && pwrite) begin
            case (paddr[5:3])
                RegScalarModes: r_scalar_modes      <= pwdata[3:0];
                RegPressure:    r_pressure_value    <= pwdata[47:0];
                RegTemperature: r_temperature_value <= pwdata[47:0];
                RegVelMode:     r_velocity_mode     <= pwdata[2:0];
                RegVelX:        r_velocity_value_x  <= pwdata[47:0];
                RegVelY:        r_velocity_value_y  <= pwdata[47:0];
                RegVelZ:        r_velocity_value_z  <= pwdata[47:0];
                RegGasConstant: r_gas_constant      <= pwdata[46:0];
                default:        r_scalar_modes      <= r_scalar_modes;
            endcase
        end
    end

    always_comb begin
        case (paddr[5:3])
            RegScalarModes: prdata = {60'b0, r_scalar_modes};
            RegPressure:    prdata = {16'b0, r_pressure_value};
            RegTemperature: prdata = {16'b0, r_temperature_value};
            RegVelMode:     prdata = {61'b0, r_velocity_mode};
            RegVelX:        prdata = {16'b0, r_velocity_value_x};
            RegVelY:        prdata = {16'b0, r_velocity_value_y};
            RegVelZ:        prdata = {16'b0, r_velocity_value_z};
            RegGasConstant: prdata = {17'b0, r_gas_constant};
            default:        prdata = '0;
        endcase
    end

    cbfv_front u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_en                (w_en),
        .i_valid             (i_in_valid),
        .i_cell_pressure     (i_cell_pressure),
        .i_cell_vel_x        (i_cell_vel_x),
        .i_cell_vel_y        (i_cell_vel_y),
        .i_cell_vel_z        (i_cell_vel_z),
        .i_cell_temperature  (i_cell_temperature),
        .i_normal_x          (i_normal_x),
        .i_normal_y          (i_normal_y),
        .i_normal_z          (i_normal_z),
        .i_scalar_modes      (r_scalar_modes),
        .i_pressure_value    (r_pressure_value),
        .i_temperature_value (r_temperature_value),
        .i_velocity_mode     (r_velocity_mode),
        .i_velocity_value_x  (r_velocity_value_x),
        .i_velocity_value_y  (r_velocity_value_y),
        .i_velocity_value_z  (r_velocity_value_z),
        .i_gas_constant      (r_gas_constant),
        .o_valid             (w_front_valid),
        .o_num               (w_num),
        .o_den               (w_den),
        .o_side              (w_front_side)
    );

    // |b| * 2^16 / |p|, carrying everything else alongside
    cbfv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_front_valid),
        .i_num   (w_num),
        .i_den   (w_den),
        .i_side  (w_front_side),
        .o_valid (w_div_valid),
        .o_quot  (w_quot),
        .o_side  (w_div_side)
    );

    // signed, saturated mass flux speed; zero pressure saturates by sign of b
    always_comb begin
        if (w_div_side.p_zero) begin
            if (w_div_side.b_zero) begin
                w_speed = '0;
            end else if (w_div_side.b_neg) begin
                w_speed = ValMin;
            end else begin
                w_speed = ValMax;
            end
        end else if (w_div_side.q_neg) begin
            w_speed = (w_quot > QuotNegLimit) ? ValMin : -$signed(w_quot[47:0]);
        end else begin
            w_speed = (w_quot > QuotPosLimit) ? ValMax : $signed(w_quot[47:0]);
        end
    end

    // select mass flux components or the precomputed face velocity
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_velocity_mode == VmMassFlux) begin
                w_face[i] = sat48(128'(r_t2_mp[i] >>> 16));
            end else begin
                w_face[i] = r_t2_side.fv[i];
            end
        end
        w_fault = (r_velocity_mode == VmMassFlux) && r_t2_side.p_zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1_valid  <= 1'b0;
            r_t2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_t1_valid  <= w_div_valid;
            r_t2_valid  <= r_t1_valid;
            r_out_valid <= r_t2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t1_ns   <= -(49'(w_speed));
            r_t1_side <= w_div_side;
            r_t2_side <= r_t1_side;
            for (int i = 0; i < 3; i++) begin
                r_t2_mp[i]    <= r_t1_ns * $signed(r_t1_side.n[i]);
                r_out_face[i] <= w_face[i];
            end
            r_out_fp    <= r_t2_side.fp;
            r_out_ft    <= r_t2_side.ft;
            r_out_fault <= w_fault;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_face_pressure    = r_out_fp;
    assign o_face_vel_x       = r_out_face[0];
    assign o_face_vel_y       = r_out_face[1];
    assign o_face_vel_z       = r_out_face[2];
    assign o_face_temperature = r_out_ft;
    assign o_divide_fault     = r_out_fault;

`include "cfd_boundary_face_values_assert.svh"

    // a divide fault only ever comes out of the mass flux path
    `CBFV_ASSERT_IMPL(a_fault_mass_flux, i_clk, i_rst_n, o_out_valid && o_divide_fault, r_velocity_mode == VmMassFlux)
    // no-slip faces carry zero velocity
    `CBFV_ASSERT_IMPL(a_noslip_zero, i_clk, i_rst_n, o_out_valid && (r_velocity_mode == VmNoSlip), (o_face_vel_x == '0) && (o_face_vel_y == '0) && (o_face_vel_z == '0))
    // a stalled output register never lets a new transaction in
    `CBFV_ASSERT_NEVER(a_no_accept_on_stall, i_clk, i_rst_n, o_out_valid && !i_out_ready && o_in_ready)

endmodule

// File: design/cbfv_front.sv
// Front pipeline: normal test, slip, surface normal, mass flux numerator.
module cbfv_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [47:0] i_cell_pressure,
    input  logic signed [47:0] i_cell_vel_x,
    input  logic signed [47:0] i_cell_vel_y,
    input  logic signed [47:0] i_cell_vel_z,
    input  logic signed [47:0] i_cell_temperature,
    input  logic signed [17:0] i_normal_x,
    input  logic signed [17:0] i_normal_y,
    input  logic signed [17:0] i_normal_z,
    input  logic [3:0]         i_scalar_modes,
    input  logic signed [47:0] i_pressure_value,
    input  logic signed [47:0] i_temperature_value,
    input  logic [2:0]         i_velocity_mode,
    input  logic signed [47:0] i_velocity_value_x,
    input  logic signed [47:0] i_velocity_value_y,
    input  logic signed [47:0] i_velocity_value_z,
    input  logic [46:0]        i_gas_constant,
    output logic               o_valid,
    output logic [63:0]        o_num,
    output logic [47:0]        o_den,
    output cbfv_pkg::t_side    o_side
);
    import cbfv_pkg::*;

    logic               r1_valid, r2_valid, r3_valid, r4_valid, r5_valid;
    logic signed [47:0] r1_p, r1_t, r2_p, r2_t, r3_p, r3_t, r4_p, r4_t;
    logic signed [47:0] r1_vel [3];
    logic signed [47:0] r2_vel [3];
    logic signed [47:0] r3_vel [3];
    logic signed [47:0] r4_vel [3];
    logic signed [17:0] r1_n [3];
    logic signed [17:0] r2_n [3];
    logic signed [17:0] r3_n [3];
    logic signed [17:0] r4_n [3];
    logic signed [65:0] r2_dp [3];
    logic signed [65:0] r2_sn [3];
    logic signed [72:0] r2_mlo;
    logic signed [71:0] r2_mhi;
    logic               r3_inflow, r4_inflow;
    logic signed [51:0] r3_nv;
    logic signed [47:0] r3_a;
    logic signed [47:0] r3_sface [3];
    logic signed [47:0] r4_sface [3];
    logic signed [69:0] r4_sp [3];
    logic signed [72:0] r4_blo;
    logic signed [71:0] r4_bhi;
    logic [63:0]        r5_num;
    logic [47:0]        r5_den;
    t_side              r5_side;

    logic signed [67:0] w_dot;
    logic signed [96:0] w_af, w_bf;
    logic signed [47:0] w_b;
    logic signed [47:0] w_fix [3];
    logic signed [47:0] w_slip [3];
    logic signed [47:0] w_fv [3];

    assign w_dot = 68'(r2_dp[0]) + 68'(r2_dp[1]) + 68'(r2_dp[2]);
    assign w_af  = (97'(r2_mhi) <<< 24) + 97'(r2_mlo);
    assign w_bf  = (97'(r4_bhi) <<< 24) + 97'(r4_blo);
    assign w_b   = sat48(128'(w_bf >>> 16));
    assign w_fix[0] = i_velocity_value_x;
    assign w_fix[1] = i_velocity_value_y;
    assign w_fix[2] = i_velocity_value_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_slip[i] = sat48(128'(56'(r4_vel[i]) - 56'(r4_sp[i] >>> 16)));
            case (i_velocity_mode)
                VmFixed:   w_fv[i] = w_fix[i];
                VmSlip:    w_fv[i] = w_slip[i];
                VmNoSlip:  w_fv[i] = '0;
                VmSurface: w_fv[i] = r4_sface[i];
                default:   w_fv[i] = r4_vel[i];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_p      <= i_cell_pressure;
            r1_t      <= i_cell_temperature;
            r1_vel[0] <= i_cell_vel_x;
            r1_vel[1] <= i_cell_vel_y;
            r1_vel[2] <= i_cell_vel_z;
            r1_n[0]   <= i_normal_x;
            r1_n[1]   <= i_normal_y;
            r1_n[2]   <= i_normal_z;

            r2_p   <= r1_p;
            r2_t   <= r1_t;
            r2_mlo <= i_velocity_value_x * $signed({1'b0, i_gas_constant[23:0]});
            r2_mhi <= i_velocity_value_x * $signed({1'b0, i_gas_constant[46:24]});

            r3_p      <= r2_p;
            r3_t      <= r2_t;
            r3_inflow <= w_dot[67];
            r3_nv     <= w_dot[67:16];
            r3_a      <= sat48(128'(w_af >>> 16));

            r4_p      <= r3_p;
            r4_t      <= r3_t;
            r4_inflow <= r3_inflow;
            r4_blo    <= r3_a * $signed({1'b0, r3_t[23:0]});
            r4_bhi    <= r3_a * $signed(r3_t[47:24]);

            for (int i = 0; i < 3; i++) begin
                r2_vel[i]   <= r1_vel[i];
                r2_n[i]     <= r1_n[i];
                r2_dp[i]    <= r1_vel[i] * r1_n[i];
                r2_sn[i]    <= i_velocity_value_x * r1_n[i];
                r3_vel[i]   <= r2_vel[i];
                r3_n[i]     <= r2_n[i];
                r3_sface[i] <= sat48(128'(r2_sn[i] >>> 16));
                r4_vel[i]   <= r3_vel[i];
                r4_n[i]     <= r3_n[i];
                r4_sface[i] <= r3_sface[i];
                r4_sp[i]    <= r3_nv * r3_n[i];
                r5_side.fv[i] <= w_fv[i];
                r5_side.n[i]  <= r4_n[i];
            end

            r5_side.fp     <= pick_scalar(i_scalar_modes[1:0], i_pressure_value, r4_p, r4_inflow);
            r5_side.ft     <= pick_scalar(i_scalar_modes[3:2], i_temperature_value, r4_t,
                                          r4_inflow);
            r5_side.p_zero <= (r4_p == '0);
            r5_side.b_zero <= (w_b == '0);
            r5_side.b_neg  <= w_b[47];
            r5_side.q_neg  <= w_b[47] ^ r4_p[47];
            r5_num         <= {mag48(w_b), 16'b0};
            r5_den         <= mag48(r4_p);
        end
    end

    assign o_valid = r5_valid;
    assign o_num   = r5_num;
    assign o_den   = r5_den;
    assign o_side  = r5_side;

endmodule

// File: design/cbfv_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module cbfv_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [63:0]     i_num,
    input  logic [47:0]     i_den,
    input  cbfv_pkg::t_side i_side,
    output logic            o_valid,
    output logic [63:0]     o_quot,
    output cbfv_pkg::t_side o_side
);
    import cbfv_pkg::*;

    logic        r_valid [QuotBits];
    logic [47:0] r_rem   [QuotBits];
    logic [63:0] r_nq    [QuotBits];
    logic [47:0] r_den   [QuotBits];
    t_side       r_side  [QuotBits];

    for (genvar g = 0; g < QuotBits; g++) begin : g_step
        logic        w_valid_in;
        logic [47:0] w_rem_in;
        logic [63:0] w_nq_in;
        logic [47:0] w_den_in;
        t_side       w_side_in;
        logic [48:0] w_trial;
        logic        w_ge;

        if (g == 0) begin : g_first
            assign w_valid_in = i_valid;
            assign w_rem_in   = '0;
            assign w_nq_in    = i_num;
            assign w_den_in   = i_den;
            assign w_side_in  = i_side;
        end else begin : g_next
            assign w_valid_in = r_valid[g-1];
            assign w_rem_in   = r_rem[g-1];
            assign w_nq_in    = r_nq[g-1];
            assign w_den_in   = r_den[g-1];
            assign w_side_in  = r_side[g-1];
        end

        // shift in the next dividend bit, subtract where it fits
        assign w_trial = {w_rem_in, w_nq_in[63]};
        assign w_ge    = (w_trial >= {1'b0, w_den_in});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else if (i_en) begin
                r_valid[g] <= w_valid_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= w_ge ? 48'(w_trial - {1'b0, w_den_in}) : w_trial[47:0];
                r_nq[g]   <= {w_nq_in[62:0], w_ge};
                r_den[g]  <= w_den_in;
                r_side[g] <= w_side_in;
            end
        end
    end

    assign o_valid = r_valid[QuotBits-1];
    assign o_quot  = r_nq[QuotBits-1];
    assign o_side  = r_side[QuotBits-1];

endmodule

// File: verif/cfd_boundary_face_values_tb.sv
// Testbench for the boundary face value block: random and directed faces checked by a scoreboard.
module cfd_boundary_face_values_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cbfv_pkg::*;

    typedef struct {
        logic signed [47:0] p, vx, vy, vz, t;
        logic signed [17:0] nx, ny, nz;
    } t_face_in;

    typedef struct {
        logic signed [47:0] fp, fx, fy, fz, ft;
        logic               fault;
    } t_face_out;

    // Hold the patch settings and predict face values from them.
    class t_face_scoreboard;
        logic [3:0]         scalar_modes = 4'd5;
        logic signed [47:0] p_set = '0, t_set = '0, vx_set = '0, vy_set = '0, vz_set = '0;
        logic [2:0]         vel_mode = VmZeroGrad;
        logic [46:0]        gas_r = 47'd18808832;
        t_face_out          pending_faces[$];
        int                 errors = 0;

        function void set_reg(logic [2:0] idx, logic [63:0] v);
            case (idx)
                RegScalarModes: scalar_modes = v[3:0];
                RegPressure:    p_set = v[47:0];
                RegTemperature: t_set = v[47:0];
                RegVelMode:     vel_mode = v[2:0];
                RegVelX:        vx_set = v[47:0];
                RegVelY:        vy_set = v[47:0];
                RegVelZ:        vz_set = v[47:0];
                default:        gas_r = v[46:0];
            endcase
        endfunction

        function logic signed [47:0] clip(logic signed [159:0] x);
            if (x > 160'sh7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
            if (x < -160'sh8000_0000_0000) return 48'sh8000_0000_0000;
            return x[47:0];
        endfunction

        // Product of two Q16 numbers, floored (arithmetic shift keeps the floor).
        function logic signed [159:0] fmul(logic signed [159:0] a, logic signed [159:0] b);
            return (a * b) >>> 16;
        endfunction

        function logic signed [47:0] scalar(logic [1:0] m, logic signed [47:0] fx,
                                            logic signed [47:0] c, logic inflow);
            if (m == SmFixed) return fx;
            if (m == SmInletOutlet) return inflow ? fx : c;
            return c;
        endfunction

        function void note_face(t_face_in f);
            logic signed [159:0] dot, nv, a, b, spd, pw;
            logic signed [159:0] vel[3], nrm[3];
            logic [159:0] q;
            t_face_out r;
            logic inflow;
            vel[0] = f.vx; vel[1] = f.vy; vel[2] = f.vz;
            nrm[0] = f.nx; nrm[1] = f.ny; nrm[2] = f.nz;
            dot = vel[0]*nrm[0] + vel[1]*nrm[1] + vel[2]*nrm[2];
            inflow = dot < 0;
            r.fp = scalar(scalar_modes[1:0], p_set, f.p, inflow);
            r.ft = scalar(scalar_modes[3:2], t_set, f.t, inflow);
            r.fault = 1'b0;
            r.fx = f.vx; r.fy = f.vy; r.fz = f.vz;
            case (vel_mode)
                VmFixed: begin
                    r.fx = vx_set; r.fy = vy_set; r.fz = vz_set;
                end
                VmSlip: begin
                    nv = dot >>> 16;
                    r.fx = clip(vel[0] - fmul(nv, nrm[0]));
                    r.fy = clip(vel[1] - fmul(nv, nrm[1]));
                    r.fz = clip(vel[2] - fmul(nv, nrm[2]));
                end
                VmNoSlip: begin
                    r.fx = '0; r.fy = '0; r.fz = '0;
                end
                VmSurface: begin
                    r.fx = clip(fmul(vx_set, nrm[0]));
                    r.fy = clip(fmul(vx_set, nrm[1]));
                    r.fz = clip(fmul(vx_set, nrm[2]));
                end
                VmMassFlux: begin
                    a = clip(fmul(vx_set, $signed({113'd0, gas_r})));
                    b = clip(fmul(a, $signed(f.t)));
                    pw = f.p;
                    if (pw == 0) begin
                        r.fault = 1'b1;
                        spd = (b > 0) ? 160'sh7FFF_FFFF_FFFF :
                              ((b < 0) ? -160'sh8000_0000_0000 : 0);
                    end else begin
                        // divide magnitudes, truncating toward zero, then saturate
                        q = ((b < 0 ? -b : b) <<< 16) / (pw < 0 ? -pw : pw);
                        spd = ((b < 0) != (pw < 0)) ? -$signed(q) : $signed(q);
                        spd = clip(spd);
                    end
                    r.fx = clip(fmul(-spd, nrm[0]));
                    r.fy = clip(fmul(-spd, nrm[1]));
                    r.fz = clip(fmul(-spd, nrm[2]));
                end
                default: ;
            endcase
            pending_faces = {pending_faces, r};
        endfunction

        function void check_face(t_face_out got);
            t_face_out e;
            if (pending_faces.size() == 0) begin
                $display("%0t: unexpected result fp=%h", $time, got.fp);
                errors++;
                return;
            end
            e = pending_faces.pop_front();
            if (got.fp !== e.fp) begin
                $display("%0t: face_pressure exp %h got %h", $time, e.fp, got.fp); errors++;
            end
            if (got.fx !== e.fx) begin
                $display("%0t: face_vel_x exp %h got %h", $time, e.fx, got.fx); errors++;
            end
            if (got.fy !== e.fy) begin
                $display("%0t: face_vel_y exp %h got %h", $time, e.fy, got.fy); errors++;
            end
            if (got.fz !== e.fz) begin
                $display("%0t: face_vel_z exp %h got %h", $time, e.fz, got.fz); errors++;
            end
            if (got.ft !== e.ft) begin
                $display("%0t: face_temperature exp %h got %h", $time, e.ft, got.ft); errors++;
            end
            if (got.fault !== e.fault) begin
                $display("%0t: divide_fault exp %b got %b", $time, e.fault, got.fault); errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0, i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [5:0] paddr = '0;
    logic [63:0] pwdata = '0, prdata;
    logic pready;
    logic i_in_valid = 1'b0, o_in_ready, o_out_valid, i_out_ready = 1'b0;
    logic signed [47:0] i_cell_pressure = '0, i_cell_vel_x = '0, i_cell_vel_y = '0;
    logic signed [47:0] i_cell_vel_z = '0, i_cell_temperature = '0;
    logic signed [17:0] i_normal_x = '0, i_normal_y = '0, i_normal_z = '0;
    logic signed [47:0] o_face_pressure, o_face_vel_x, o_face_vel_y, o_face_vel_z;
    logic signed [47:0] o_face_temperature;
    logic o_divide_fault;

    t_face_scoreboard sb = new();
    bit calm = 1'b0;   // long stretch with no idling on either side

    cfd_boundary_face_values dut (.*);

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Generous limit: the full pipeline depth plus ~650 faces with heavy idling fit well inside.
    initial begin
        #4ms;
        $display("== FAIL ==");
        $finish;
    end

    // Receiver: stall at random, check every accepted result.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_face('{fp: o_face_pressure, fx: o_face_vel_x, fy: o_face_vel_y,
                            fz: o_face_vel_z, ft: o_face_temperature, fault: o_divide_fault});
        end
        i_out_ready <= calm || ($urandom_range(99) >= 24);
    end

    // Write one register: setup cycle then access cycle.
    task automatic write_reg(logic [2:0] idx, logic [63:0] v);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 3'b000}; pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    // Drive one face and hold it until the block takes it; keep valid up for the next.
    task automatic send_face(t_face_in f);
        while (!calm && $urandom_range(99) < 24) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cell_pressure <= f.p; i_cell_vel_x <= f.vx; i_cell_vel_y <= f.vy;
        i_cell_vel_z <= f.vz; i_cell_temperature <= f.t;
        i_normal_x <= f.nx; i_normal_y <= f.ny; i_normal_z <= f.nz;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_face(f);
    endtask

    function automatic logic signed [47:0] rand_val();
        case ($urandom_range(5))
            0: return 48'sh7FFF_FFFF_FFFF;
            1: return 48'sh8000_0000_0000;
            2: return '0;
            3: return $signed(48'($urandom_range(32'h7FFF_FFFF))) - 48'sh4000_0000;
            default: return 48'({$urandom, $urandom});
        endcase
    endfunction

    function automatic logic signed [17:0] rand_norm();
        case ($urandom_range(4))
            0: return 18'sd65536;
            1: return -18'sd65536;
            2: return 18'($urandom);          // out of range, used as given
            default: return $signed(18'($urandom_range(131072))) - 18'sd65536;
        endcase
    endfunction

    function automatic t_face_in rand_face();
        t_face_in f;
        f.p = ($urandom_range(9) == 0) ? '0 : rand_val();
        f.vx = rand_val(); f.vy = rand_val(); f.vz = rand_val(); f.t = rand_val();
        f.nx = rand_norm(); f.ny = rand_norm(); f.nz = rand_norm();
        return f;
    endfunction

    // Drop valid and drain the pipeline before touching the registers.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending_faces.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    initial begin
        t_face_in f;
        logic signed [47:0] edges[3];
        edges[0] = 48'sh7FFF_FFFF_FFFF; edges[1] = 48'sh8000_0000_0000; edges[2] = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: each velocity mode with extreme and zero-pressure faces.
        for (int m = 0; m < 8; m++) begin
            write_reg(RegVelMode, 64'(m));
            write_reg(RegScalarModes, 64'($urandom_range(15)));
            write_reg(RegVelX, m[0] ? 64'h7FFF_FFFF_FFFF : 64'h8000_0000_0000);
            for (int k = 0; k < 3; k++) begin
                f = '{p: (k == 2) ? 48'sd0 : edges[k], vx: edges[k], vy: edges[(k+1)%3],
                      vz: edges[(k+2)%3], t: edges[(k+1)%3],
                      nx: (k == 0) ? 18'sd65536 : -18'sd65536, ny: 18'sh20000, nz: 18'sh1FFFF};
                send_face(f);
            end
            settle();
        end

        // Random phases, each with a fresh register setting.
        for (int ph = 0; ph < 12; ph++) begin
            write_reg(RegScalarModes, 64'($urandom_range(15)));
            write_reg(RegPressure, 64'(rand_val()));
            write_reg(RegTemperature, 64'(rand_val()));
            write_reg(RegVelMode, (ph < 6) ? 64'(VmMassFlux) : 64'($urandom_range(7)));
            write_reg(RegVelX, 64'(rand_val()));
            write_reg(RegVelY, 64'(rand_val()));
            write_reg(RegVelZ, 64'(rand_val()));
            write_reg(RegGasConstant, (ph == 0) ? 64'h7FFF_FFFF_FFFF :
                      (ph == 1) ? 64'd0 : 64'($urandom_range(32'h0FFF_FFFF)));
            calm = (ph == 7);
            for (int i = 0; i < 50; i++) send_face(rand_face());
            calm = 1'b0;
            settle();
        end

        if (sb.errors == 0 && sb.pending_faces.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
